// File: rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, sampled on the rising clock edge, off during reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// File: rtl/core/ucd_pkg.sv
// Types, constants and the CRC-8 helper for the uplink command deframer.
package ucd_pkg;

   localparam int FRAME_BYTES = 6;
   localparam int FILL_BITS   = 3;
   localparam int CRC_SPAN    = 3;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_TOP  = 8'h80;
   localparam logic [7:0] CRC_INIT = 8'h00;

   localparam logic [7:0] START_MARKER_RESET = 8'd126;
   localparam logic [7:0] END_MARKER_RESET   = 8'd127;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_START_MARKER = 1'd0,
      REG_END_MARKER   = 1'd1
   } csr_index_type;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      byte_type start_marker;
      byte_type end_marker;
   } marker_type;

   typedef struct packed {
      logic               command_valid;
      byte_type           opcode;
      logic signed [15:0] argument;
      logic               frame_rejected;
      logic [31:0]        good_frames;
      logic [31:0]        bad_frames;
      logic [31:0]        byte_total;
   } result_type;

   // One byte through CRC-8, MSB first, no reflection.
   function automatic byte_type crc8_byte(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/ucd_frame_core.sv
// Frame buffer, CRC check, resync and counters of the uplink command deframer.
`include "assert_macros.svh"

module ucd_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ucd_pkg::byte_type   rx_byte,
   input  ucd_pkg::marker_type markers,
   output ucd_pkg::result_type result
);

   localparam int FB = ucd_pkg::FRAME_BYTES;

   ucd_pkg::byte_type store_ff [FB];
   ucd_pkg::byte_type store_in [FB];
   ucd_pkg::byte_type cand     [FB];

   logic [ucd_pkg::FILL_BITS-1:0] fill_ff, fill_in;
   logic [ucd_pkg::FILL_BITS-1:0] shift;
   logic [31:0] good_ff, good_in;
   logic [31:0] bad_ff, bad_in;
   logic [31:0] byte_ff, byte_in;
   ucd_pkg::byte_type last_ff, last_in;
   ucd_pkg::byte_type crc;

   logic taking, full, frame_ok, good, bad;

   always_comb begin
      // Buffer as it stands with the new byte dropped in at the fill position.
      for (int j = 0; j < FB; j++) begin
         cand[j] = (fill_ff == ucd_pkg::FILL_BITS'(j)) ? rx_byte : store_ff[j];
      end

      taking = (fill_ff != '0) || (rx_byte == markers.start_marker);
      full   = taking && (fill_ff == ucd_pkg::FILL_BITS'(FB - 1));

      crc = ucd_pkg::CRC_INIT;
      for (int i = 0; i < ucd_pkg::CRC_SPAN; i++) begin
         crc = ucd_pkg::crc8_byte(crc, cand[1 + i]);
      end

      frame_ok = (cand[FB-1] == markers.end_marker) && (crc == cand[4]);
      good     = full && frame_ok;
      bad      = full && !frame_ok;

      // Earliest later start marker wins; zero means none found.
      shift = '0;
      for (int k = FB - 1; k >= 1; k--) begin
         if (cand[k] == markers.start_marker) begin
            shift = ucd_pkg::FILL_BITS'(k);
         end
      end

      store_in = store_ff;
      fill_in  = fill_ff;
      if (taking) begin
         store_in = cand;
         fill_in  = fill_ff + 1'b1;
      end
      if (good) begin
         fill_in = '0;
      end
      if (bad) begin
         fill_in = '0;
         for (int k = 1; k < FB; k++) begin
            if (shift == ucd_pkg::FILL_BITS'(k)) begin
               for (int j = 0; j < FB - k; j++) begin
                  store_in[j] = cand[j + k];
               end
               fill_in = ucd_pkg::FILL_BITS'(FB - k);
            end
         end
      end

      byte_in = byte_ff + 32'd1;
      good_in = good ? good_ff + 32'd1 : good_ff;
      bad_in  = bad ? bad_ff + 32'd1 : bad_ff;
      last_in = good ? cand[1] : last_ff;

      result.command_valid  = good;
      result.opcode         = last_in;
      result.argument       = good ? $signed({cand[2], cand[3]}) : 16'sd0;
      result.frame_rejected = bad;
      result.good_frames    = good_in;
      result.bad_frames     = bad_in;
      result.byte_total     = byte_in;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         store_ff <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         good_ff <= '0;
         bad_ff  <= '0;
         byte_ff <= '0;
         last_ff <= '0;
      end else if (step) begin
         fill_ff <= fill_in;
         good_ff <= good_in;
         bad_ff  <= bad_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   `ASSERT_NEVER(a_good_and_bad, clock, reset, step && result.command_valid && result.frame_rejected)
   `ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > ucd_pkg::FILL_BITS'(FB - 1))
   `ASSERT_PROP(a_good_empties, clock, reset, step && result.command_valid |=> fill_ff == '0)
   `ASSERT_PROP(a_byte_count, clock, reset, step |=> byte_ff == $past(byte_ff) + 32'd1)

endmodule

// File: rtl/core/uplink_command_deframer.sv
// Top level of the uplink command deframer: handshake, input and result registers, CSRs.
`include "assert_macros.svh"

// Takes one received byte per transfer and gives one result per byte. Throughput is
// one byte per clock while the result side is not stalling: a byte is held in the input
// register, and the frame update (store byte, CRC-8 over opcode and argument, end-marker
// check, resync shift, counters) is combinational logic from it into the result register,
// from which the result is offered. A stalled result holds the pipe; the input register
// still takes one more byte. No clearing pass after reset: the frame store is only read
// at positions already written.
module uplink_command_deframer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_command_valid,
   output logic [7:0]                          rsp_opcode,
   output logic signed [15:0]                  rsp_argument,
   output logic                                rsp_frame_rejected,
   output logic [31:0]                         rsp_good_frames,
   output logic [31:0]                         rsp_bad_frames,
   output logic [31:0]                         rsp_byte_total,
   input  logic                                csr_write,
   input  logic [ucd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ucd_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   ucd_pkg::marker_type markers_ff;
   ucd_pkg::byte_type   in_byte_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   ucd_pkg::result_type out_ff;
   ucd_pkg::result_type core_result;
   logic                advance;
   logic                req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         markers_ff.start_marker <= ucd_pkg::START_MARKER_RESET;
         markers_ff.end_marker   <= ucd_pkg::END_MARKER_RESET;
      end else if (csr_write) begin
         unique case (ucd_pkg::csr_index_type'(csr_index))
            ucd_pkg::REG_START_MARKER: markers_ff.start_marker <= csr_data;
            ucd_pkg::REG_END_MARKER:   markers_ff.end_marker   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   ucd_frame_core u_frame_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .markers (markers_ff),
      .result  (core_result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_command_valid  = out_ff.command_valid;
   assign rsp_opcode         = out_ff.opcode;
   assign rsp_argument       = out_ff.argument;
   assign rsp_frame_rejected = out_ff.frame_rejected;
   assign rsp_good_frames    = out_ff.good_frames;
   assign rsp_bad_frames     = out_ff.bad_frames;
   assign rsp_byte_total     = out_ff.byte_total;

   `ASSERT_NEVER(a_stall_needs_item, clock, reset, req_stall && !in_valid_ff)
   `ASSERT_PROP(a_advance_fills_out, clock, reset, advance |=> out_valid_ff)
   `ASSERT_PROP(a_stall_holds_pipe, clock, reset, out_valid_ff && rsp_stall |-> !advance)

endmodule
